// File: src/sbsad_pkg.sv
// Shared types and constants of the subpixel block SAD engine.
`default_nettype none

package sbsad_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W = 2;
  localparam int PHASE_COUNT = 1 << PHASE_W;
  localparam int WEIGHT_W = 8;
  localparam int WEIGHT_FULL_W = WEIGHT_W + 1;
  localparam int WEIGHT_ONE = 256;
  localparam int HSUM_W = SAMPLE_W + WEIGHT_W;
  localparam int VSUM_W = HSUM_W + WEIGHT_W;
  localparam int COST_W = 40;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam int OVERSAMPLE_FACTOR_DEF = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [WEIGHT_FULL_W-1:0] weight_full_t;
  typedef logic [COST_W-1:0] cost_t;

  // One classified word as it waits between the front and the back.
  typedef struct packed {
    sample_t top_left;
    sample_t top_right;
    sample_t bottom_left;
    sample_t bottom_right;
    sample_t cur;
    weight_t wx2;
    weight_t wy2;
    logic    last;
  } item_t;

endpackage

`default_nettype wire

// File: src/sbsad_pixel_if.sv
// Handshake channel that carries one sample word into the engine.
`default_nettype none

interface sbsad_pixel_if;
  import sbsad_pkg::*;

  logic                 valid;
  logic                 ready;
  sample_t              ref_top_left;
  sample_t              ref_top_right;
  sample_t              ref_bottom_left;
  sample_t              ref_bottom_right;
  sample_t              cur_sample;
  logic [PHASE_W-1:0]   phase_x;
  logic [PHASE_W-1:0]   phase_y;
  logic                 block_end;

  modport source (
    output valid, ref_top_left, ref_top_right, ref_bottom_left, ref_bottom_right,
           cur_sample, phase_x, phase_y, block_end,
    input  ready
  );

  modport sink (
    input  valid, ref_top_left, ref_top_right, ref_bottom_left, ref_bottom_right,
           cur_sample, phase_x, phase_y, block_end,
    output ready
  );

endinterface

`default_nettype wire

// File: src/sbsad_cost_if.sv
// Handshake channel that carries one block cost word out of the engine.
`default_nettype none

interface sbsad_cost_if;
  import sbsad_pkg::*;

  logic  valid;
  logic  ready;
  cost_t block_cost;
  logic  cost_saturated;

  modport source (
    output valid, block_cost, cost_saturated,
    input  ready
  );

  modport sink (
    input  valid, block_cost, cost_saturated,
    output ready
  );

endinterface

`default_nettype wire

// File: src/sbsad_front.sv
// Input stage: takes sample words and turns the subpixel phases into weights.
`default_nettype none

module sbsad_front #(
  parameter int OVERSAMPLE_FACTOR = sbsad_pkg::OVERSAMPLE_FACTOR_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  sbsad_pixel_if.sink          pixel,
  output logic                 push_valid,
  input  logic                 push_ready,
  output sbsad_pkg::item_t     push_item
);
  import sbsad_pkg::*;

  // Weight of the far sample for each phase; a phase at or above the factor wraps.
  localparam weight_t PHASE_WEIGHT [PHASE_COUNT] = '{
    WEIGHT_W'(((0 % OVERSAMPLE_FACTOR) * WEIGHT_ONE) / OVERSAMPLE_FACTOR),
    WEIGHT_W'(((1 % OVERSAMPLE_FACTOR) * WEIGHT_ONE) / OVERSAMPLE_FACTOR),
    WEIGHT_W'(((2 % OVERSAMPLE_FACTOR) * WEIGHT_ONE) / OVERSAMPLE_FACTOR),
    WEIGHT_W'(((3 % OVERSAMPLE_FACTOR) * WEIGHT_ONE) / OVERSAMPLE_FACTOR)
  };

  logic  held_valid;
  item_t held_item;
  logic  take;

  assign pixel.ready = !held_valid || push_ready;
  assign take        = pixel.valid && pixel.ready;
  assign push_valid  = held_valid;
  assign push_item   = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (push_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_item.top_left     <= pixel.ref_top_left;
      held_item.top_right    <= pixel.ref_top_right;
      held_item.bottom_left  <= pixel.ref_bottom_left;
      held_item.bottom_right <= pixel.ref_bottom_right;
      held_item.cur          <= pixel.cur_sample;
      held_item.wx2          <= PHASE_WEIGHT[pixel.phase_x];
      held_item.wy2          <= PHASE_WEIGHT[pixel.phase_y];
      held_item.last         <= pixel.block_end;
    end
  end

endmodule

`default_nettype wire

// File: src/sbsad_queue.sv
// Short first-in first-out queue between the front and the back.
`default_nettype none

module sbsad_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sbsad_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sbsad_pkg::item_t pop_item
);
  import sbsad_pkg::*;

  item_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;
  logic                 push;
  logic                 pop;

  assign push_ready = count != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: src/sbsad_back.sv
// Blend, difference and saturating accumulation pipeline with its result register.
`default_nettype none

module sbsad_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  sbsad_pkg::item_t pop_item,
  sbsad_cost_if.source     cost
);
  import sbsad_pkg::*;

  // All stages step together whenever the result register can move.
  logic advance;

  // Stage 1: horizontal blends of the top and bottom rows.
  logic              s1_valid;
  logic [HSUM_W-1:0] s1_top;
  logic [HSUM_W-1:0] s1_bottom;
  weight_t           s1_wy2;
  sample_t           s1_cur;
  logic              s1_last;

  // Stage 2: vertical blend, floored to a sample.
  logic    s2_valid;
  sample_t s2_ref;
  sample_t s2_cur;
  logic    s2_last;

  // Stage 3: absolute difference.
  logic    s3_valid;
  sample_t s3_diff;
  logic    s3_last;

  // Running sum and result register.
  cost_t acc;
  logic  acc_sat;
  logic  out_valid;
  cost_t out_cost;
  logic  out_sat;

  weight_full_t      wx1;
  weight_full_t      wy1;
  logic [HSUM_W:0]   top_next;
  logic [HSUM_W:0]   bottom_next;
  logic [VSUM_W:0]   vert_next;
  sample_t           diff_next;
  logic [COST_W:0]   sum_wide;
  cost_t             acc_next;
  logic              acc_sat_next;

  assign advance   = !out_valid || cost.ready;
  assign pop_ready = advance;

  assign cost.valid          = out_valid;
  assign cost.block_cost     = out_cost;
  assign cost.cost_saturated = out_sat;

  always_comb begin
    wx1 = WEIGHT_FULL_W'(WEIGHT_ONE) - WEIGHT_FULL_W'(pop_item.wx2);
    top_next = (HSUM_W+1)'(pop_item.top_left) * (HSUM_W+1)'(wx1)
             + (HSUM_W+1)'(pop_item.top_right) * (HSUM_W+1)'(pop_item.wx2);
    bottom_next = (HSUM_W+1)'(pop_item.bottom_left) * (HSUM_W+1)'(wx1)
                + (HSUM_W+1)'(pop_item.bottom_right) * (HSUM_W+1)'(pop_item.wx2);
  end

  always_comb begin
    wy1 = WEIGHT_FULL_W'(WEIGHT_ONE) - WEIGHT_FULL_W'(s1_wy2);
    vert_next = (VSUM_W+1)'(s1_top) * (VSUM_W+1)'(wy1)
              + (VSUM_W+1)'(s1_bottom) * (VSUM_W+1)'(s1_wy2);
  end

  always_comb begin
    if (s2_ref >= s2_cur) begin
      diff_next = s2_ref - s2_cur;
    end else begin
      diff_next = s2_cur - s2_ref;
    end
  end

  // A carry out of the sum means it passed the maximum, so it holds there.
  always_comb begin
    sum_wide = {1'b0, acc} + (COST_W+1)'(s3_diff);
    if (sum_wide[COST_W]) begin
      acc_next     = COST_MAX;
      acc_sat_next = 1'b1;
    end else begin
      acc_next     = sum_wide[COST_W-1:0];
      acc_sat_next = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      acc       <= '0;
      acc_sat   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= pop_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && s3_last;
      if (s3_valid) begin
        if (s3_last) begin
          acc     <= '0;
          acc_sat <= 1'b0;
        end else begin
          acc     <= acc_next;
          acc_sat <= acc_sat_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_top    <= top_next[HSUM_W-1:0];
      s1_bottom <= bottom_next[HSUM_W-1:0];
      s1_wy2    <= pop_item.wy2;
      s1_cur    <= pop_item.cur;
      s1_last   <= pop_item.last;
      s2_ref    <= vert_next[VSUM_W-1:WEIGHT_W+WEIGHT_W];
      s2_cur    <= s1_cur;
      s2_last   <= s1_last;
      s3_diff   <= diff_next;
      s3_last   <= s2_last;
      if (s3_valid && s3_last) begin
        out_cost <= acc_next;
        out_sat  <= acc_sat_next;
      end
    end
  end

`ifndef SYNTH
  a_sat_means_max: assert property (@(posedge clk) disable iff (rst)
    acc_sat |-> acc == COST_MAX)
    else $error("accumulator flagged saturated below its maximum");

  a_out_sat_means_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |-> out_cost == COST_MAX)
    else $error("saturated block cost below its maximum");

  a_clear_after_block: assert property (@(posedge clk) disable iff (rst)
    (advance && s3_valid && s3_last) |=> (acc == '0 && !acc_sat && out_valid))
    else $error("running sum not cleared after a block result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(acc) && $stable(acc_sat) && $stable(s3_valid)))
    else $error("pipeline moved while the result register was stalled");
`endif

endmodule

`default_nettype wire

// File: src/subpixel_block_sad_unit.sv
// Top level of the subpixel block SAD engine: front stage, queue and back pipeline.
//
//   Channel | Modport | Payload                                       | Meaning
//   pixel   | sink    | four reference samples, cur_sample, phases,   | one component
//           |         | block_end                                     | sample word
//   cost    | source  | block_cost, cost_saturated                    | one word per block
//
// The engine takes one sample word per clock cycle in steady state while the cost
// output is not stalled. A word passes through the front register, the queue and
// the back pipeline stages (horizontal blend, vertical blend, absolute difference)
// before the accumulation step loads the result register.
// The back pipeline steps all of its stages together and holds them while a block
// cost waits untaken in the result register; the four-word queue lets the front keep
// taking words during such a stall until it fills.
// The synchronous reset clears all valid flags and the running sum; there is no
// clearing pass and the block is ready as soon as reset is released.
`default_nettype none

module subpixel_block_sad_unit #(
  parameter int OVERSAMPLE_FACTOR = sbsad_pkg::OVERSAMPLE_FACTOR_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sbsad_pixel_if.sink  pixel,
  sbsad_cost_if.source cost
);
  import sbsad_pkg::*;

  // Words from the front into the queue.
  logic  push_valid;
  logic  push_ready;
  item_t push_item;

  // Words from the queue into the back pipeline.
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // The front maps each phase to its blend weight, so the back only multiplies.
  sbsad_front #(
    .OVERSAMPLE_FACTOR (OVERSAMPLE_FACTOR)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // The queue decouples the two halves so a stalled result does not stop input at once.
  sbsad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back blends, takes the difference and keeps the saturating sum of the block.
  sbsad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cost      (cost)
  );

endmodule

`default_nettype wire
